[rtl/golden_spiral_point_splatter_macros.svh]
// Assertion helpers for the spiral splatter checker
`ifndef GOLDEN_SPIRAL_POINT_SPLATTER_MACROS_SVH
`define GOLDEN_SPIRAL_POINT_SPLATTER_MACROS_SVH
// implication under reset
`define GSPS_ASSERT_IMP(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("gsps check failed");
// implication, next cycle
`define GSPS_ASSERT_NXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("gsps check failed");
`endif

[rtl/gsps_pkg.sv]
// ----------------------------------------------------------------------------
// gsps_pkg
// Shared types and constants of the golden spiral splatter.
// ----------------------------------------------------------------------------
package gsps_pkg;
	localparam int FRAME_WIDTH_DEF = 1024;
	localparam int FRAME_HEIGHT_DEF = 768;
	localparam int POINT_BITS_DEF = 16;
	localparam int CORDIC_STEPS = 16;
	localparam logic [31:0] GOLDEN_Q32 = 32'h9E37_79B9;
	localparam logic [15:0] GAIN_Q16 = 16'd39797;
	localparam logic [7:0] ALPHA_MIN = 8'hC0;
	// CORDIC vector width: radius up to ~86 px in Q16 plus headroom
	localparam int VW = 26;
	localparam int ZW = 26;

	typedef enum logic [1:0] {
		KIND_SPLAT = 2'd0,
		KIND_CLEAR = 2'd1,
		KIND_READ  = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	function automatic logic [ZW-1:0] atan_q24(input int i);
		logic [ZW-1:0] a;
		unique case (i)
			0: a = 26'd2097152; 1: a = 26'd1238021; 2: a = 26'd654136;
			3: a = 26'd332050; 4: a = 26'd166669; 5: a = 26'd83416;
			6: a = 26'd41718; 7: a = 26'd20860; 8: a = 26'd10430;
			9: a = 26'd5215; 10: a = 26'd2608; 11: a = 26'd1304;
			12: a = 26'd652; 13: a = 26'd326; 14: a = 26'd163;
			default: a = 26'd81;
		endcase
		return a;
	endfunction
endpackage

[rtl/gsps_sqrt.sv]
// ----------------------------------------------------------------------------
// gsps_sqrt
// Pipelined integer square root of m<<16, one result bit per stage.
// ----------------------------------------------------------------------------
module gsps_sqrt #(
	parameter int PB = 16
) (
	input logic clk,
	input logic en,
	input logic [PB-1:0] m,
	output logic [PB+7:0] root
);
	import gsps_pkg::*;
	localparam int RW = PB + 8;
	localparam int VWS = 2 * PB + 16;
	localparam int RMW = VWS + 2;

	logic [VWS-1:0] v_s [RW+1];
	logic [RMW-1:0] rem_s [RW+1];
	logic [RW-1:0] rt_s [RW+1];

	always_comb begin
		v_s[0] = VWS'({m, 16'd0});
		rem_s[0] = '0;
		rt_s[0] = '0;
	end

	for (genvar k = 0; k < RW; k++) begin : g_st
		logic [RMW-1:0] rem_n, trial;
		always_comb begin
			rem_n = {rem_s[k][RMW-3:0], v_s[k][VWS-1 -: 2]};
			trial = RMW'({rt_s[k], 2'b01});
		end
		always_ff @(posedge clk) begin
			if (en) begin
				v_s[k+1] <= {v_s[k][VWS-3:0], 2'b00};
				if (rem_n >= trial) begin
					rem_s[k+1] <= rem_n - trial;
					rt_s[k+1] <= {rt_s[k][RW-2:0], 1'b1};
				end else begin
					rem_s[k+1] <= rem_n;
					rt_s[k+1] <= {rt_s[k][RW-2:0], 1'b0};
				end
			end
		end
	end
	assign root = rt_s[RW];
endmodule

[rtl/gsps_cordic.sv]
// ----------------------------------------------------------------------------
// gsps_cordic
// Rotation-mode CORDIC, one iteration per register stage.
// ----------------------------------------------------------------------------
module gsps_cordic (
	input logic clk,
	input logic en,
	input logic signed [gsps_pkg::VW-1:0] x_in,
	input logic signed [gsps_pkg::ZW-1:0] z_in,
	output logic signed [gsps_pkg::VW-1:0] x_out,
	output logic signed [gsps_pkg::VW-1:0] y_out
);
	import gsps_pkg::*;
	logic signed [VW-1:0] x_s [CORDIC_STEPS+1];
	logic signed [VW-1:0] y_s [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];

	always_comb begin
		x_s[0] = x_in;
		y_s[0] = '0;
		z_s[0] = z_in;
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_it
		always_ff @(posedge clk) begin
			if (en) begin
				if (!z_s[i][ZW-1]) begin
					x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] - $signed(atan_q24(i));
				end else begin
					x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
					y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
					z_s[i+1] <= z_s[i] + $signed(atan_q24(i));
				end
			end
		end
	end
	assign x_out = x_s[CORDIC_STEPS];
	assign y_out = y_s[CORDIC_STEPS];
endmodule

[rtl/golden_spiral_point_splatter.sv]
// ----------------------------------------------------------------------------
// golden_spiral_point_splatter
// Vogel spiral splatter into an 8-bit intensity frame with clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one word per operation: splat
//   a spiral point, clear a pixel, read a pixel, or no-op. Every input word
//   yields exactly one output word on out_valid/out_stall.
//   Throughput: one word per cycle when the output is not stalled. Stages: PB+8
//   square-root stages, one divide-by-3 stage, one gain-multiply stage, 16
//   CORDIC stages, a position stage and a memory read stage; the blend and
//   write happen in the cycle that loads the output register.
//   The frame store is a single-port-write, single-read memory; a blend or
//   clear still in the write stage is forwarded to a younger read of the
//   same pixel, so back-to-back hits on one pixel are exact.
//   Reset clears only valid bits; the frame is undefined until cleared.
//   A stall on the output freezes the whole pipeline in place (nothing lost
//   or repeated); in_stall follows out_stall when the output register is
//   full.
// ----------------------------------------------------------------------------
module golden_spiral_point_splatter #(
	parameter int FRAME_WIDTH = gsps_pkg::FRAME_WIDTH_DEF,
	parameter int FRAME_HEIGHT = gsps_pkg::FRAME_HEIGHT_DEF,
	parameter int POINT_BITS = gsps_pkg::POINT_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic [1:0] kind,
	input logic [17:0] center_x,
	input logic [17:0] center_y,
	input logic [15:0] point_index,
	input logic [9:0] addr_x,
	input logic [9:0] addr_y,
	output logic out_valid,
	input logic out_stall,
	output logic [9:0] hit_x,
	output logic [9:0] hit_y,
	output logic [7:0] level,
	output logic [31:0] argb_word,
	output logic in_bounds
);
	import gsps_pkg::*;
	localparam int PB = POINT_BITS;
	localparam int RW = PB + 8;
	localparam int AW = $clog2(FRAME_WIDTH * FRAME_HEIGHT);
	localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
	// sqrt, div3, gain, CORDIC, position
	localparam int PD = RW + 3 + CORDIC_STEPS;
	localparam int unsigned MMAX = (1 << PB) - 1;
	localparam int LW = PB + 8;
	// level divide by MMAX as reciprocal multiply, exact for m*255 < 2^LW
	localparam int LS = 2 * PB + 8;
	localparam longint unsigned LRECIP =
		((64'd1 << LS) + 64'(MMAX) - 64'd1) / 64'(MMAX);

	typedef struct packed {
		logic [1:0] kind;
		logic [17:0] cx;
		logic [17:0] cy;
		logic [PB-1:0] m;
		logic [9:0] ax;
		logic [9:0] ay;
		logic [1:0] q;
	} side_t;

	// whole pipeline advances unless the output register holds a stalled word
	logic en;
	assign en = !(out_valid && out_stall);
	assign in_stall = !en;

	// ---------------- stage 0: intake, golden angle ----------------
	logic [PB-1:0] m_in;
	logic [31:0] turn_prod;
	logic [15:0] t_in;
	assign m_in = PB'(point_index);
	assign turn_prod = 32'(m_in) * GOLDEN_Q32;
	assign t_in = turn_prod[31:16];

	logic [ZW-1:0] z_in;
	assign z_in = ZW'({t_in[13:0], 8'd0});

	side_t side_in;
	assign side_in = '{kind: kind, cx: center_x, cy: center_y, m: m_in,
		ax: addr_x, ay: addr_y, q: t_in[15:14]};

	// side data and valid travel alongside the arithmetic
	side_t side_s [PD+1];
	logic vld_s [PD+1];
	logic [ZW-1:0] z_d [RW+3];
	assign side_s[0] = side_in;
	assign vld_s[0] = in_valid;
	assign z_d[0] = z_in;

	for (genvar k = 0; k < PD; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (en) side_s[k+1] <= side_s[k];
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[k+1] <= 1'b0;
			else if (en) vld_s[k+1] <= vld_s[k];
		end
	end
	for (genvar k = 0; k < RW + 2; k++) begin : g_zd
		always_ff @(posedge clk) begin
			if (en) z_d[k+1] <= z_d[k];
		end
	end

	// ---------------- radius ----------------
	logic [RW-1:0] root;
	gsps_sqrt #(.PB(PB)) u_sqrt (.clk(clk), .en(en), .m(m_in), .root(root));

	// divide by 3 via reciprocal multiply: floor(r*0x2AAAB >> 19) exact for r<2^19
	localparam int DW = RW + 18;
	logic [DW-1:0] div_prod;
	logic [RW-1:0] r8_s1;
	assign div_prod = DW'(root) * DW'(18'h2AAAB);
	always_ff @(posedge clk) begin
		if (en) r8_s1 <= RW'(div_prod >> 19);
	end

	logic [RW+16:0] gain_prod;
	logic signed [VW-1:0] x0_s2;
	assign gain_prod = (RW+17)'(r8_s1) * (RW+17)'(GAIN_Q16);
	always_ff @(posedge clk) begin
		if (en) x0_s2 <= $signed(VW'(gain_prod >> 8));
	end

	logic signed [VW-1:0] cx_o, cy_o;
	gsps_cordic u_cordic (.clk(clk), .en(en), .x_in(x0_s2), .z_in(z_d[RW+2]),
		.x_out(cx_o), .y_out(cy_o));

	// ---------------- position ----------------
	side_t sp;
	assign sp = side_s[PD-1];
	logic signed [VW-1:0] rx, ry;
	always_comb begin
		unique case (sp.q)
			2'd1: begin rx = -cy_o; ry = cx_o; end
			2'd2: begin rx = -cx_o; ry = -cy_o; end
			2'd3: begin rx = cy_o; ry = -cx_o; end
			default: begin rx = cx_o; ry = cy_o; end
		endcase
	end
	logic signed [27:0] px, py;
	assign px = $signed({2'b00, sp.cx, 8'd0}) + 28'(rx);
	assign py = $signed({2'b00, sp.cy, 8'd0}) + 28'(ry);

	logic on_x, on_y;
	logic [11:0] pxi, pyi;
	always_comb begin
		pxi = px[27] ? 12'd0 : px[27:16];
		pyi = py[27] ? 12'd0 : py[27:16];
		on_x = (px > -28'sd65536) && (32'(pxi) < FRAME_WIDTH);
		on_y = (py > -28'sd65536) && (32'(pyi) < FRAME_HEIGHT);
	end

	logic [LW-1:0] lvl_prod;
	logic [2*PB+16:0] lvl_rp;
	logic [7:0] lvl_pos;
	assign lvl_prod = LW'(sp.m) * LW'(255);
	assign lvl_rp = (2*PB+17)'(lvl_prod) * (2*PB+17)'(LRECIP);
	assign lvl_pos = 8'd255 - lvl_rp[LS +: 8];

	// position result registered at the last side stage
	logic [9:0] hx_p, hy_p, hx_n, hy_n;
	logic [7:0] lv_p, lv_n;
	logic wr_p, rd_p, blend_p, inb_p;
	logic wr_n, rd_n, blend_n, inb_n;
	logic [AW-1:0] ad_p, ad_n;
	always_comb begin
		lv_n = 8'd0;
		wr_n = 1'b0;
		rd_n = 1'b0;
		blend_n = 1'b0;
		inb_n = 1'b0;
		hx_n = 10'd0;
		hy_n = 10'd0;
		ad_n = '0;
		unique case (kind_t'(sp.kind))
			KIND_SPLAT: begin
				lv_n = lvl_pos;
				if (on_x && on_y) begin
					hx_n = 10'(pxi);
					hy_n = 10'(pyi);
					ad_n = AW'(32'(pyi) * FRAME_WIDTH + 32'(pxi));
					inb_n = 1'b1;
					blend_n = 1'b1;
					rd_n = 1'b1;
				end
			end
			KIND_CLEAR, KIND_READ: begin
				hx_n = sp.ax;
				hy_n = sp.ay;
				if (32'(sp.ax) < FRAME_WIDTH && 32'(sp.ay) < FRAME_HEIGHT) begin
					ad_n = AW'(32'(sp.ay) * FRAME_WIDTH + 32'(sp.ax));
					wr_n = (sp.kind == KIND_CLEAR);
					rd_n = (sp.kind == KIND_READ);
				end
			end
			default: ;
		endcase
	end
	always_ff @(posedge clk) begin
		if (en) begin
			lv_p <= lv_n;
			wr_p <= wr_n;
			rd_p <= rd_n;
			blend_p <= blend_n;
			inb_p <= inb_n;
			hx_p <= hx_n;
			hy_p <= hy_n;
			ad_p <= ad_n;
		end
	end

	// ---------------- memory read / blend ----------------
	logic [7:0] mem [DEPTH];
	logic [7:0] rdata_q;
	logic [9:0] hx_m, hy_m;
	logic [7:0] lv_m;
	logic clr_m, rd_m, blend_m, inb_m, vld_m;
	logic [AW-1:0] ad_m;
	// write stage
	logic wen_w;
	logic [AW-1:0] ad_w;
	logic [7:0] wd_w;

	always_ff @(posedge clk) begin
		if (en) begin
			rdata_q <= mem[ad_p];
			hx_m <= hx_p; hy_m <= hy_p; lv_m <= lv_p;
			clr_m <= wr_p; rd_m <= rd_p; blend_m <= blend_p;
			inb_m <= inb_p; ad_m <= ad_p;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_m <= 1'b0;
		else if (en) vld_m <= vld_s[PD];
	end

	// forward the write of the word one ahead (written at same edge as read)
	logic fwd_q;
	logic [7:0] fwd_d_q;
	always_ff @(posedge clk) begin
		if (en) begin
			fwd_q <= wen_w && (ad_w == ad_p);
			fwd_d_q <= wd_w;
		end
	end
	logic [7:0] cur;
	assign cur = fwd_q ? fwd_d_q : rdata_q;

	always_comb begin
		wen_w = vld_m && (clr_m || blend_m);
		ad_w = ad_m;
		if (clr_m) wd_w = 8'd0;
		else wd_w = (cur < lv_m) ? lv_m : cur;
	end
	always_ff @(posedge clk) begin
		if (en && wen_w) mem[ad_w] <= wd_w;
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (en) out_valid <= vld_m;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			hit_x <= hx_m;
			hit_y <= hy_m;
			in_bounds <= inb_m;
			if (rd_m && !blend_m) begin
				level <= cur;
				argb_word <= {(cur > ALPHA_MIN) ? cur : ALPHA_MIN, cur, cur, cur};
			end else begin
				level <= lv_m;
				argb_word <= 32'd0;
			end
		end
	end
endmodule

[rtl/gsps_checker.sv]
// ----------------------------------------------------------------------------
// gsps_checker
// Port-level checks of the spiral splatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "golden_spiral_point_splatter_macros.svh"
module gsps_checker (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic [9:0] hit_x,
	input logic [31:0] argb_word,
	input logic in_bounds
);
	`GSPS_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(hit_x))
	`GSPS_ASSERT_IMP(a_stall, out_valid && out_stall, in_stall)
	`GSPS_ASSERT_IMP(a_splat_no_argb, out_valid && in_bounds, argb_word == 32'd0)
	`GSPS_ASSERT_IMP(a_alpha, out_valid && argb_word != 32'd0, argb_word[31:30] == 2'b11)
endmodule

bind golden_spiral_point_splatter gsps_checker u_chk (.clk(clk), .arst_n(arst_n),
	.in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
	.hit_x(hit_x), .argb_word(argb_word), .in_bounds(in_bounds));
